// File: design/skt_pkg.sv
// Package holding the shared types and codes of the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

   // Action codes of a request beat.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // Status codes of a response beat.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_BEYOND    = 2'd3;

   // Widths of the response fields that are fixed by the interface.
   localparam int COUNT_W = 7;
   localparam int WHERE_W = 6;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic [1:0]          action;
      logic                commit;
      logic signed [31:0]  key;
      logic [31:0]         payload;
      logic [WHERE_W-1:0]  position;
   } cmd_type;

   // What a cell shows its neighbours.
   typedef struct packed {
      logic signed [31:0]  key;
      logic [31:0]         payload;
      logic                valid;
      logic                ge_or_empty;
      logic                match;
   } link_type;

   // A cell's share of the response: zero unless the cell is the one the action touches.
   typedef struct packed {
      logic                sel;
      logic [WHERE_W-1:0]  where;
      logic signed [31:0]  key;
      logic [31:0]         payload;
   } share_type;

endpackage

// File: design/skt_if.sv
// Handshake interfaces of the request and response channels.
`timescale 1ns / 1ps

interface skt_req_if;
   import skt_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic signed [31:0]  key;
   logic [31:0]         payload;
   logic [WHERE_W-1:0]  position;

   modport source (output valid, action, key, payload, position, input ready);
   modport sink   (input valid, action, key, payload, position, output ready);
endinterface

interface skt_rsp_if;
   import skt_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [COUNT_W-1:0]  record_count;
   logic [WHERE_W-1:0]  where;
   logic signed [31:0]  out_key;
   logic [31:0]         out_payload;

   modport source (output valid, status, record_count, where, out_key, out_payload,
                   input ready);
   modport sink   (input valid, status, record_count, where, out_key, out_payload,
                   output ready);
endinterface

// File: design/skt_cell.sv
// One cell of the sorted row: holds a record and shifts with its neighbours.
`timescale 1ns / 1ps

module skt_cell
   import skt_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  link_type  left,
   input  link_type  right,
   output link_type  self_link,
   output share_type share
);

   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic [31:0]        payload_ff;
   logic [31:0]        payload_in;
   logic               valid_ff;
   logic               valid_in;
   logic               key_ge;
   logic               ge_or_empty;
   logic               ge_valid;
   logic               match;
   logic               ins_first;
   logic               del_first;
   logic               rd_hit;
   logic               sel_rec;
   logic               sel_where;

   // Comparisons against the broadcast key.
   always_comb begin
      key_ge      = key_ff >= cmd.key;
      ge_or_empty = !valid_ff || key_ge;
      ge_valid    = valid_ff && key_ge;
      match       = valid_ff && (key_ff == cmd.key);
      // The row is sorted, so the first cell of a run is found from the left flag alone.
      ins_first   = ge_or_empty && !left.ge_or_empty;
      del_first   = match && !left.match;
      rd_hit      = valid_ff && (INDEX < (1 << WHERE_W)) &&
                    (cmd.position == WHERE_W'(INDEX));
   end

   assign self_link.key         = key_ff;
   assign self_link.payload     = payload_ff;
   assign self_link.valid       = valid_ff;
   assign self_link.ge_or_empty = ge_or_empty;
   assign self_link.match       = match;

   // Contribution to the response.
   always_comb begin
      sel_rec   = 1'b0;
      sel_where = 1'b0;
      case (cmd.action)
         ACT_INSERT: begin
            sel_where = ins_first;
         end
         ACT_DELETE: begin
            sel_rec   = del_first;
            sel_where = del_first;
         end
         ACT_READ: begin
            sel_rec   = rd_hit;
            sel_where = rd_hit;
         end
         default: begin
            sel_rec   = 1'b0;
            sel_where = 1'b0;
         end
      endcase
      share.sel     = sel_rec;
      share.where   = sel_where ? WHERE_W'(INDEX) : '0;
      share.key     = sel_rec ? key_ff : '0;
      share.payload = sel_rec ? payload_ff : '0;
   end

   // Next contents: shift right on insert, shift left on delete.
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      valid_in   = valid_ff;
      if (cmd.commit) begin
         case (cmd.action)
            ACT_INSERT: begin
               if (left.ge_or_empty) begin
                  key_in     = left.key;
                  payload_in = left.payload;
                  valid_in   = left.valid;
               end else if (ge_or_empty) begin
                  key_in     = cmd.key;
                  payload_in = cmd.payload;
                  valid_in   = 1'b1;
               end
            end
            ACT_DELETE: begin
               if (ge_valid) begin
                  key_in     = right.key;
                  payload_in = right.payload;
                  valid_in   = right.valid;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

// File: design/sorted_key_table.sv
// Top level of the sorted key table: command capture, cell row and response register.
`timescale 1ns / 1ps

// Sorted key table. Records of a signed 32-bit key and a 32-bit payload are held
// in ascending key order in a row of DEPTH cells. A request beat carries an
// action (insert, delete by key, read at position); every request gives exactly
// one response beat with a status, the record count after the action, the
// position touched and, for delete and read, the record itself.
// Timing: a request beat is taken in the idle state and its command registered;
// in the execute state all cells compare against the key at once and shift in
// one move, and the response is registered when the action executes. A new
// request is taken only after the action in flight has executed, set by the
// capture-then-execute sequence around the cell row.
// The response register parts the two channels: a request may be taken while a
// response still waits; if the receiver stalls, the executing action holds
// until the waiting beat has been taken.
// Reset (synchronous, active high) empties the table and clears both channels.
// Records are not cleared; empty cells are never read.
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   skt_req_if.sink           req_chan,
   skt_rsp_if.source         rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic               state_ff;
   logic               state_in;
   cmd_type            cmd_ff;
   cmd_type            cmd;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;
   logic [CNT_W-1:0]   rcount_ff;
   logic [WHERE_W-1:0] where_ff;
   logic [WHERE_W-1:0] where_in;
   logic signed [31:0] okey_ff;
   logic [31:0]        opay_ff;
   logic               req_fire;
   logic               exec_fire;
   logic               full;
   logic               found;
   logic               insert_ok;
   logic               delete_ok;
   share_type          total;

   link_type  links  [DEPTH];
   share_type shares [DEPTH];
   link_type  edge_left;
   link_type  edge_right;

   // Handshake and sequencing.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign exec_fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command broadcast to the row; contents change only when the action commits.
   assign full = links[DEPTH-1].valid;

   always_comb begin
      cmd        = cmd_ff;
      cmd.commit = exec_fire &&
                   !((cmd_ff.action == ACT_INSERT) && full) &&
                   !((cmd_ff.action == ACT_DELETE) && !found);
   end

   // Constant neighbours at both ends of the row.
   always_comb begin
      edge_left             = '0;
      edge_left.ge_or_empty = 1'b0;
      edge_left.match       = 1'b0;
      edge_right            = '0;
      edge_right.valid      = 1'b0;
   end

   // The row of cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      skt_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left      ((i == 0) ? edge_left : links[(i == 0) ? 0 : i - 1]),
         .right     ((i == DEPTH - 1) ? edge_right : links[(i == DEPTH - 1) ? i : i + 1]),
         .self_link (links[i]),
         .share     (shares[i])
      );
   end

   // Gather the cell shares; at most one cell is selected at a time.
   always_comb begin
      total = '0;
      for (int i = 0; i < DEPTH; i++) begin
         total = total | shares[i];
      end
   end

   assign found     = total.sel;
   assign insert_ok = (cmd_ff.action == ACT_INSERT) && !full;
   assign delete_ok = (cmd_ff.action == ACT_DELETE) && found;

   // Status and count of the action in flight.
   always_comb begin
      status_in = STS_OK;
      where_in  = total.where;
      count_in  = count_ff;
      case (cmd_ff.action)
         ACT_INSERT: begin
            if (full) begin
               status_in = STS_FULL;
               where_in  = '0;
            end
         end
         ACT_DELETE: begin
            if (!found) begin
               status_in = STS_NOT_FOUND;
            end
         end
         ACT_READ: begin
            if (!found) begin
               status_in = STS_BEYOND;
            end
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
      if (exec_fire && insert_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (exec_fire && delete_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         cmd_ff.action   <= req_chan.action;
         cmd_ff.commit   <= 1'b0;
         cmd_ff.key      <= req_chan.key;
         cmd_ff.payload  <= req_chan.payload;
         cmd_ff.position <= req_chan.position;
      end
      if (exec_fire) begin
         status_ff <= status_in;
         rcount_ff <= count_in;
         where_ff  <= where_in;
         okey_ff   <= total.key;
         opay_ff   <= total.payload;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.record_count = COUNT_W'(rcount_ff);
   assign rsp_chan.where        = where_ff;
   assign rsp_chan.out_key      = okey_ff;
   assign rsp_chan.out_payload  = opay_ff;

endmodule

// File: dv/sorted_key_table_test.sv
// Self-checking testbench of the sorted key table: random and directed beats, scoreboard.
`timescale 1ns / 1ps

import skt_pkg::*;

// The fields of one response beat, as the scoreboard holds and compares them.
typedef struct packed {
   logic [1:0]          status;
   logic [COUNT_W-1:0]  record_count;
   logic [WHERE_W-1:0]  where;
   logic signed [31:0]  out_key;
   logic [31:0]         out_payload;
} rsp_beat_type;

// Scoreboard: keeps its own sorted table and the queue of response beats still due.
class sorted_table_scoreboard;
   localparam int TABLE_DEPTH = 64;

   logic signed [31:0]  key_tbl [TABLE_DEPTH];
   logic [31:0]         payload_tbl [TABLE_DEPTH];
   int                  count;
   int                  mismatches;
   rsp_beat_type        expected_rsp [$];

   function new();
      count = 0;
      mismatches = 0;
   endfunction

   task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   function int pending();
      return expected_rsp.size();
   endfunction

   // Applies one action to the table and returns the response it should give.
   function rsp_beat_type apply_action(logic [1:0] act, logic signed [31:0] k,
                                       logic [31:0] p, logic [WHERE_W-1:0] pos);
      rsp_beat_type r;
      int           at;
      int           i;
      bit           hit;
      r = '0;
      r.status = STS_OK;
      at = 0;
      hit = 1'b0;
      case (act)
         ACT_INSERT: begin
            if (count >= TABLE_DEPTH) begin
               r.status = STS_FULL;
            end else begin
               // The new record goes in front of the first key that is not smaller.
               at = count;
               for (i = 0; i < count; i++) begin
                  if (!hit && key_tbl[i] >= k) begin
                     at = i;
                     hit = 1'b1;
                  end
               end
               for (i = count; i > at; i--) begin
                  key_tbl[i] = key_tbl[i-1];
                  payload_tbl[i] = payload_tbl[i-1];
               end
               key_tbl[at] = k;
               payload_tbl[at] = p;
               count++;
               r.where = WHERE_W'(at);
            end
         end
         ACT_DELETE: begin
            // Only the first record with a matching key is removed.
            for (i = 0; i < count; i++) begin
               if (!hit && key_tbl[i] == k) begin
                  at = i;
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               r.status = STS_NOT_FOUND;
            end else begin
               r.where = WHERE_W'(at);
               r.out_key = key_tbl[at];
               r.out_payload = payload_tbl[at];
               for (i = at; i < count - 1; i++) begin
                  key_tbl[i] = key_tbl[i+1];
                  payload_tbl[i] = payload_tbl[i+1];
               end
               count--;
            end
         end
         ACT_READ: begin
            if (pos >= count) begin
               r.status = STS_BEYOND;
            end else begin
               r.where = pos;
               r.out_key = key_tbl[pos];
               r.out_payload = payload_tbl[pos];
            end
         end
         default: begin
         end
      endcase
      r.record_count = COUNT_W'(count);
      return r;
   endfunction

   function void note_request(logic [1:0] act, logic signed [31:0] k, logic [31:0] p,
                              logic [WHERE_W-1:0] pos);
      expected_rsp.push_back(apply_action(act, k, p, pos));
   endfunction

   task check_response(rsp_beat_type got);
      rsp_beat_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("response beat with no request waiting");
         return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status)
         report_mismatch($sformatf("status got %0d, expected %0d", got.status, want.status));
      if (got.record_count !== want.record_count)
         report_mismatch($sformatf("record_count got %0d, expected %0d",
                                   got.record_count, want.record_count));
      if (got.where !== want.where)
         report_mismatch($sformatf("where got %0d, expected %0d", got.where, want.where));
      if (got.out_key !== want.out_key)
         report_mismatch($sformatf("out_key got %h, expected %h", got.out_key, want.out_key));
      if (got.out_payload !== want.out_payload)
         report_mismatch($sformatf("out_payload got %h, expected %h",
                                   got.out_payload, want.out_payload));
   endtask
endclass

module sorted_key_table_test;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam longint TIMEOUT_NS = 4_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit idle_sender = 1'b1;
   bit idle_receiver = 1'b1;
   bit hold_off_request = 1'b0;

   sorted_table_scoreboard table_sb;
   rsp_beat_type           seen_rsp;

   skt_req_if req_chan ();
   skt_rsp_if rsp_chan ();

   sorted_key_table #(.DEPTH(64)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one request beat after a random gap and returns at the falling edge after it is taken.
   task automatic send_request(input logic [1:0] act, input logic signed [31:0] k,
                               input logic [31:0] p, input logic [WHERE_W-1:0] pos);
      int gap;
      gap = idle_sender ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.key      <= k;
      req_chan.payload  <= p;
      req_chan.position <= pos;
      do @(posedge clock); while (!req_chan.ready);
      table_sb.note_request(act, k, p, pos);
      @(negedge clock);
   endtask

   // Stops offering and waits until every response due has been taken.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (table_sb.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Keys are drawn from the table, from a pool of awkward values or at random.
   function automatic logic signed [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3 && table_sb.count > 0)
         return table_sb.key_tbl[$urandom_range(0, table_sb.count - 1)];
      if (sel < 6) begin
         case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            default: return 32'($urandom_range(0, 15)) - 32'd8;
         endcase
      end
      return $urandom;
   endfunction

   // Random beats with the given shares of inserts and deletes; the rest are mostly reads.
   task automatic run_random(input int n, input int ins_pct, input int del_pct);
      int               j;
      int               r;
      logic [1:0]       act;
      logic [WHERE_W-1:0] pos;
      for (j = 0; j < n; j++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            act = ACT_UNUSED;
         else if (r < 3 + ins_pct)
            act = ACT_INSERT;
         else if (r < 3 + ins_pct + del_pct)
            act = ACT_DELETE;
         else
            act = ACT_READ;
         if ($urandom_range(0, 3) == 0)
            pos = WHERE_W'($urandom);
         else
            pos = WHERE_W'($urandom_range(0, table_sb.count));
         send_request(act, pick_key(), $urandom, pos);
      end
   endtask

   // Response monitor: every beat taken is checked against the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_rsp.status       = rsp_chan.status;
         seen_rsp.record_count = rsp_chan.record_count;
         seen_rsp.where        = rsp_chan.where;
         seen_rsp.out_key      = rsp_chan.out_key;
         seen_rsp.out_payload  = rsp_chan.out_payload;
         table_sb.check_response(seen_rsp);
      end
   end

   // Receiver: a random stall before each beat, or a long hold-off when asked for one.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = idle_receiver ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // Watchdog for a run that hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("sorted_key_table_test: done, errors");
      $finish;
   end

   // Main sequence: reset, directed beats, then random phases.
   initial begin
      table_sb = new();
      req_chan.valid    = 1'b0;
      req_chan.action   = ACT_INSERT;
      req_chan.key      = '0;
      req_chan.payload  = '0;
      req_chan.position = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty table, extreme keys, equal keys and the ok, not found and beyond statuses.
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd0);
      send_request(ACT_DELETE, 32'sd5,          32'h0,         6'd0);
      send_request(ACT_UNUSED, 32'sd0,          32'h0,         6'd0);
      send_request(ACT_INSERT, 32'sd0,          32'h0000_0000, 6'd0);
      send_request(ACT_INSERT, 32'sh7fff_ffff,  32'hffff_ffff, 6'd0);
      send_request(ACT_INSERT, 32'sh8000_0000,  32'h1234_5678, 6'd0);
      send_request(ACT_INSERT, -32'sd1,         32'ha5a5_a5a5, 6'd0);
      send_request(ACT_INSERT, 32'sd0,          32'h5a5a_5a5a, 6'd0);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd0);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd2);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd3);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd4);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd5);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd63);
      send_request(ACT_DELETE, 32'sd0,          32'h0,         6'd0);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd2);
      send_request(ACT_DELETE, 32'sh7fff_ffff,  32'h0,         6'd0);
      send_request(ACT_DELETE, 32'sh8000_0000,  32'h0,         6'd0);
      send_request(ACT_DELETE, 32'sd7,          32'h0,         6'd0);
      send_request(ACT_UNUSED, 32'sd9,          32'hffff_ffff, 6'd63);
      send_request(ACT_INSERT, 32'sd1,          32'h8000_0001, 6'd0);
      send_request(ACT_READ,   32'sd0,          32'h0,         6'd63);
      wait_drained();

      // Filling phase under a long receiver hold-off, with the sender never idle.
      idle_sender = 1'b0;
      hold_off_request = 1'b1;
      run_random(325, 60, 20);
      wait_drained();

      // Balanced phase with no idling on either side.
      idle_receiver = 1'b0;
      run_random(325, 35, 35);
      wait_drained();

      // Draining phase.
      idle_sender = 1'b1;
      idle_receiver = 1'b1;
      run_random(325, 15, 60);
      wait_drained();

      // Filling again, to spend time against a full table.
      run_random(325, 70, 10);
      wait_drained();

      // Read-heavy phase with the receiver always ready.
      idle_receiver = 1'b0;
      run_random(325, 30, 20);
      wait_drained();

      // Final drain towards an empty table.
      idle_receiver = 1'b1;
      run_random(325, 10, 70);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
         $display("sorted_key_table_test: done, clean");
      end else begin
         $display("sorted_key_table_test: done, errors");
      end
      $finish;
   end

endmodule
